// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RNG RTL files.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/xsrng_pkg.sv =====
// Package for the xorshift128+ RNG: command/status types, controller states and constants.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package xsrng_pkg;

    // Input word kinds
    localparam logic KIND_INIT = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // Source codes on the result word
    localparam logic [1:0] SRC_HW      = 2'd0;
    localparam logic [1:0] SRC_PRNG    = 2'd1;
    localparam logic [1:0] SRC_HW_FAIL = 2'd2;
    localparam logic [1:0] SRC_EARLY   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_TSC_FIRST   = 2'd0;
    localparam logic [1:0] CFG_TSC_SECOND  = 2'd1;
    localparam logic [1:0] CFG_CLOCK_BYTES = 2'd2;
    localparam logic [1:0] CFG_HAS_HW      = 2'd3;

    localparam logic [63:0] GOLDEN_INC   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_ONE  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_TWO  = 64'h94D0_49BB_1331_11EB;
    localparam logic [63:0] SEED_ONE_INC = 64'h6C62_272E_07BB_0142;
    localparam logic [63:0] CLOCK_HIGH   = 64'hDEAD_BEEF_0000_0000;
    localparam logic [63:0] ZERO_SUB_A   = 64'hDEAD_C0DE_DEAD_C0DE;
    localparam logic [63:0] ZERO_SUB_B   = 64'hCAFE_BABE_CAFE_BABE;
    localparam logic [63:0] HW_FAIL_MASK = 64'hA5A5_A5A5_A5A5_A5A5;
    localparam logic [63:0] EARLY_MASK   = 64'h5555_5555_5555_5555;
    localparam logic [63:0] RESET_A      = 64'h1234_5678_9ABC_DEF0;
    localparam logic [63:0] RESET_B      = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DRAW,
        OP_LOAD,
        OP_XS30,
        OP_MUL_ONE,
        OP_XS27,
        OP_MUL_TWO,
        OP_FIN,
        OP_STEP,
        OP_READY
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_XS30,
        S_MUL_ONE,
        S_XS27,
        S_MUL_TWO,
        S_FIN,
        S_WARM,
        S_READY
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] phase;
        logic       seed_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xsrng_ctrl.sv =====
// Sequencer for the RNG: handshake on the input side and the seeding/warm-up steps.
// Depends on xsrng_pkg and assert_macros.svh; drives the datapath by command.
`default_nettype none
`include "assert_macros.svh"

module xsrng_ctrl #(
    parameter int WARMUP_STEPS = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire                     kind,
    input  xsrng_pkg::dp_status_t   status,
    output xsrng_pkg::dp_cmd_t      cmd
);
    import xsrng_pkg::*;

    localparam int WCW = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;
    localparam logic [WCW-1:0] WARM_LAST = WCW'((WARMUP_STEPS > 0) ? WARMUP_STEPS - 1 : 0);

    state_t         state_reg, state_next;
    logic [1:0]     phase_reg, phase_next;
    logic           seed_reg, seed_next;
    logic [WCW-1:0] warm_cnt_reg, warm_cnt_next;
    logic           in_acc;

    assign in_stall = (state_reg != S_IDLE) || status.out_busy;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= 2'd0;
            seed_reg     <= 1'b0;
            warm_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            seed_reg     <= seed_next;
            warm_cnt_reg <= warm_cnt_next;
        end
    end

    // Next state and sequencing counters
    always_comb
    begin
        state_next    = state_reg;
        seed_next     = seed_reg;
        warm_cnt_next = warm_cnt_reg;
        phase_next    = 2'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && kind == KIND_INIT)
                begin
                    state_next = S_LOAD;
                    seed_next  = 1'b0;
                end
            end
            S_LOAD:  state_next = S_XS30;
            S_XS30:  state_next = S_MUL_ONE;
            S_MUL_ONE:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    state_next = S_XS27;
                end
            end
            S_XS27:  state_next = S_MUL_TWO;
            S_MUL_TWO:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                warm_cnt_next = '0;
                if (!seed_reg)
                begin
                    state_next = S_LOAD;
                    seed_next  = 1'b1;
                end
                else if (WARMUP_STEPS == 0)
                begin
                    state_next = S_READY;
                end
                else
                begin
                    state_next = S_WARM;
                end
            end
            S_WARM:
            begin
                warm_cnt_next = warm_cnt_reg + WCW'(1);
                if (warm_cnt_reg == WARM_LAST)
                begin
                    state_next = S_READY;
                end
            end
            S_READY: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath command
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.phase    = phase_reg;
        cmd.seed_sel = seed_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && kind == KIND_DRAW)
                begin
                    cmd.op = OP_DRAW;
                end
            end
            S_LOAD:    cmd.op = OP_LOAD;
            S_XS30:    cmd.op = OP_XS30;
            S_MUL_ONE: cmd.op = OP_MUL_ONE;
            S_XS27:    cmd.op = OP_XS27;
            S_MUL_TWO: cmd.op = OP_MUL_TWO;
            S_FIN:     cmd.op = OP_FIN;
            S_WARM:    cmd.op = OP_STEP;
            S_READY:   cmd.op = OP_READY;
            default:   cmd.op = OP_NONE;
        endcase
    end

    `ASSERT_IMPL(a_phase_in_mul, clk, rst_n, (phase_reg != 2'd0),
        (state_reg == S_MUL_ONE || state_reg == S_MUL_TWO), "phase set outside multiply")
    `ASSERT_NEXT(a_init_starts, clk, rst_n, (in_acc && kind == KIND_INIT),
        (state_reg == S_LOAD && !seed_reg), "init word did not start seed zero")
    `ASSERT_NEXT(a_second_seed, clk, rst_n, (state_reg == S_FIN && !seed_reg),
        (state_reg == S_LOAD && seed_reg), "seed one did not follow seed zero")

endmodule

`default_nettype wire

// ===== hw/rtl/xsrng_dp.sv =====
// Datapath for the RNG: config registers, generator state, seed mixer with a
// shared 32x32 multiplier, and the output register. Depends on xsrng_pkg.
`default_nettype none

module xsrng_dp (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_write_en,
    input  wire [1:0]               cfg_index,
    input  wire [63:0]              cfg_data,
    input  wire [63:0]              tsc_now,
    input  wire [63:0]              hw_word,
    input  wire                     hw_ok,
    input  xsrng_pkg::dp_cmd_t      cmd,
    output xsrng_pkg::dp_status_t   status,
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic [63:0]             random_word,
    output logic [1:0]              source
);
    import xsrng_pkg::*;

    logic [63:0] tsc_first_reg, tsc_second_reg;
    logic [23:0] clock_bytes_reg;
    logic        has_hw_reg;

    logic [63:0] state_a_reg, state_a_next;
    logic [63:0] state_b_reg, state_b_next;
    logic        ready_reg, ready_next;

    logic [63:0] z_reg, z_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mul_k;
    logic [31:0] mul_a, mul_b;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] word_reg, word_next;
    logic [1:0]  src_reg, src_next;

    logic [63:0] gx, gen_b, gen_out;
    logic [63:0] seed0, seed1, fin, load_val;

    assign out_valid       = out_valid_reg;
    assign random_word     = word_reg;
    assign source          = src_reg;
    assign status.out_busy = out_valid_reg && out_stall;

    // One xorshift128+ step on the registered state
    always_comb
    begin
        gx      = state_a_reg ^ (state_a_reg << 23);
        gx      = gx ^ (gx >> 17);
        gen_b   = gx ^ state_b_reg ^ (state_b_reg >> 26);
        gen_out = state_b_reg + gen_b;
    end

    assign seed0    = tsc_first_reg ^ (tsc_second_reg << 17) ^ (tsc_second_reg >> 47);
    assign seed1    = CLOCK_HIGH | {40'd0, clock_bytes_reg};
    assign load_val = cmd.seed_sel ? (seed1 + SEED_ONE_INC) : (seed0 + GOLDEN_INC);
    assign fin      = acc_reg ^ (acc_reg >> 31);

    // Low 64 bits of z * k from three 32x32 partial products
    assign mul_k     = (cmd.op == OP_MUL_TWO) ? MIX_MUL_TWO : MIX_MUL_ONE;
    assign mul_a     = (cmd.phase == 2'd2) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (cmd.phase == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    assign prod_next = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        state_a_next   = state_a_reg;
        state_b_next   = state_b_reg;
        ready_next     = ready_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (cmd.op) inside
            OP_DRAW:
            begin
                out_valid_next = 1'b1;
                if (!ready_reg)
                begin
                    word_next = tsc_now ^ EARLY_MASK;
                    src_next  = SRC_EARLY;
                end
                else if (has_hw_reg && hw_ok)
                begin
                    word_next = hw_word;
                    src_next  = SRC_HW;
                end
                else
                begin
                    state_a_next = state_b_reg;
                    state_b_next = gen_b;
                    word_next    = has_hw_reg ? (gen_out ^ HW_FAIL_MASK) : gen_out;
                    src_next     = has_hw_reg ? SRC_HW_FAIL : SRC_PRNG;
                end
            end
            OP_LOAD: z_next = load_val;
            OP_XS30: z_next = z_reg ^ (z_reg >> 30);
            OP_MUL_ONE, OP_MUL_TWO:
            begin
                case (cmd.phase)
                    2'd0:    acc_next = acc_reg;
                    2'd1:    acc_next = prod_reg;
                    default: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                endcase
            end
            OP_XS27: z_next = acc_reg ^ (acc_reg >> 27);
            OP_FIN:
            begin
                // Substitute a fixed word for an all-zero seed
                if (cmd.seed_sel)
                begin
                    state_b_next = (fin != 64'd0) ? fin : ZERO_SUB_B;
                end
                else
                begin
                    state_a_next = (fin != 64'd0) ? fin : ZERO_SUB_A;
                end
            end
            OP_STEP:
            begin
                state_a_next = state_b_reg;
                state_b_next = gen_b;
            end
            OP_READY: ready_next = 1'b1;
            default:  ready_next = ready_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsc_first_reg   <= 64'd0;
            tsc_second_reg  <= 64'd0;
            clock_bytes_reg <= 24'd0;
            has_hw_reg      <= 1'b0;
            state_a_reg     <= RESET_A;
            state_b_reg     <= RESET_B;
            ready_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_TSC_FIRST:   tsc_first_reg   <= cfg_data;
                    CFG_TSC_SECOND:  tsc_second_reg  <= cfg_data;
                    CFG_CLOCK_BYTES: clock_bytes_reg <= cfg_data[23:0];
                    CFG_HAS_HW:      has_hw_reg      <= cfg_data[0];
                    default:         has_hw_reg      <= has_hw_reg;
                endcase
            end
            state_a_reg   <= state_a_next;
            state_b_reg   <= state_b_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg    <= z_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        word_reg <= word_next;
        src_reg  <= src_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/xorshift128plus_rng_with_seeding.sv =====
// Top level of the xorshift128+ random word source with splitmix64 seeding.
// Depends on xsrng_pkg, xsrng_ctrl and xsrng_dp.
`default_nettype none

// A draw word is accepted whenever the block is idle and its output register is
// free or being taken, and its result lands in the output register in the next
// cycle, so draws run at one word per cycle while the receiver takes them. An
// init word holds the input side stalled through the steps of both seeds (each:
// load, shift-xor, four multiply phases, shift-xor, four multiply phases,
// finish), paced by the single shared 32x32 multiplier that builds each 64-bit
// product over three partial products; then through each warm-up step and the
// step that marks the generator ready. Init gives no result word.
module xorshift128plus_rng_with_seeding #(
    parameter int WARMUP_STEPS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write_en,
    input  wire [1:0]   cfg_index,
    input  wire [63:0]  cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         kind,
    input  wire [63:0]  tsc_now,
    input  wire [63:0]  hw_word,
    input  wire         hw_ok,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [63:0] random_word,
    output logic [1:0]  source
);
    import xsrng_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    xsrng_ctrl #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    xsrng_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tsc_now      (tsc_now),
        .hw_word      (hw_word),
        .hw_ok        (hw_ok),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_word  (random_word),
        .source       (source)
    );

endmodule

`default_nettype wire

// ===== tb/xorshift128plus_rng_with_seeding_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the xorshift128+ word source: mirrors the config registers,
// predicts each draw and compares the result words. Depends on xsrng_pkg.
module xorshift128plus_rng_with_seeding_checker #(
    parameter int WARMUP_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [63:0] tsc_now,
    input  logic [63:0] hw_word,
    input  logic        hw_ok,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] random_word,
    input  logic [1:0]  source,
    output int          error_count,
    output int          pending_count
);
    import xsrng_pkg::*;

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  src;
    } draw_result_t;

    logic [63:0] tsc_first_q;
    logic [63:0] tsc_second_q;
    logic [23:0] clock_bytes_q;
    logic        has_hw_q;

    logic [63:0] gen_a;
    logic [63:0] gen_b;
    logic        gen_ready;

    draw_result_t expected_draws[$];

    function automatic logic [63:0] splitmix_finish(input logic [63:0] z,
                                                    input logic [63:0] inc);
        logic [63:0] m;
        m = z + inc;
        m = (m ^ (m >> 30)) * MIX_MUL_ONE;
        m = (m ^ (m >> 27)) * MIX_MUL_TWO;
        return m ^ (m >> 31);
    endfunction

    function logic [63:0] advance_generator();
        logic [63:0] x;
        logic [63:0] y;
        x = gen_a;
        y = gen_b;
        gen_a = y;
        x ^= x << 23;
        x ^= x >> 17;
        x ^= y ^ (y >> 26);
        gen_b = x;
        return gen_a + gen_b;
    endfunction

    task reseed_and_warm();
        logic [63:0] s0;
        logic [63:0] s1;
        s0 = tsc_first_q ^ (tsc_second_q << 17) ^ (tsc_second_q >> 47);
        s1 = {40'h0, clock_bytes_q} | CLOCK_HIGH;
        s0 = splitmix_finish(s0, GOLDEN_INC);
        s1 = splitmix_finish(s1, SEED_ONE_INC);
        // a zero seed would lock the generator at zero; substitute
        gen_a = (s0 != 64'h0) ? s0 : ZERO_SUB_A;
        gen_b = (s1 != 64'h0) ? s1 : ZERO_SUB_B;
        for (int i = 0; i < WARMUP_STEPS; i++)
            void'(advance_generator());
        gen_ready = 1'b1;
    endtask

    function draw_result_t predict_draw(input logic [63:0] t, input logic [63:0] h,
                                        input logic o);
        draw_result_t r;
        if (!gen_ready)
        begin
            r.word = t ^ EARLY_MASK;
            r.src  = SRC_EARLY;
        end
        else if (has_hw_q)
        begin
            if (o)
            begin
                r.word = h;
                r.src  = SRC_HW;
            end
            else
            begin
                r.word = advance_generator() ^ HW_FAIL_MASK;
                r.src  = SRC_HW_FAIL;
            end
        end
        else
        begin
            r.word = advance_generator();
            r.src  = SRC_PRNG;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t want;
        if (!rst_n)
        begin
            tsc_first_q   = 64'h0;
            tsc_second_q  = 64'h0;
            clock_bytes_q = 24'h0;
            has_hw_q      = 1'b0;
            gen_a         = RESET_A;
            gen_b         = RESET_B;
            gen_ready     = 1'b0;
            expected_draws.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_TSC_FIRST:   tsc_first_q   = cfg_data;
                    CFG_TSC_SECOND:  tsc_second_q  = cfg_data;
                    CFG_CLOCK_BYTES: clock_bytes_q = cfg_data[23:0];
                    CFG_HAS_HW:      has_hw_q      = cfg_data[0];
                    default: ;
                endcase
            end
            // a result never comes out in the cycle its draw goes in, so compare first
            if (out_valid && !out_stall)
            begin
                if (expected_draws.size() == 0)
                begin
                    $error("unexpected word: random_word %h source %0d", random_word, source);
                    error_count++;
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (random_word !== want.word)
                    begin
                        $error("random_word: expected %h, got %h", want.word, random_word);
                        error_count++;
                    end
                    if (source !== want.src)
                    begin
                        $error("source: expected %0d, got %0d", want.src, source);
                        error_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind == KIND_INIT)
                    reseed_and_warm();
                else
                    expected_draws.push_back(predict_draw(tsc_now, hw_word, hw_ok));
            end
            pending_count = expected_draws.size();
        end
    end

endmodule

// ===== tb/xorshift128plus_rng_with_seeding_tb.sv =====
`timescale 1ns / 1ps
// Top of the xorshift128+ word source testbench: clock, reset, config writes and
// draw/init stimulus. Depends on xsrng_pkg, the block and its checker.
module xorshift128plus_rng_with_seeding_tb;
    import xsrng_pkg::*;

    localparam int WARMUP          = 16;
    localparam int SETTLE_CYCLES   = 25 + WARMUP + 20;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [63:0] tsc_now;
    logic [63:0] hw_word;
    logic        hw_ok;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] random_word;
    logic [1:0]  source;

    int error_count;
    int pending_count;
    int sender_idle_pct;
    int stall_pct;
    int hold_trigger;
    int hold_seen;
    int hold_left;
    int cycle_count;

    xorshift128plus_rng_with_seeding #(
        .WARMUP_STEPS(WARMUP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .tsc_now     (tsc_now),
        .hw_word     (hw_word),
        .hw_ok       (hw_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .random_word (random_word),
        .source      (source)
    );

    xorshift128plus_rng_with_seeding_checker #(
        .WARMUP_STEPS(WARMUP)
    ) scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .tsc_now      (tsc_now),
        .hw_word      (hw_word),
        .hw_ok        (hw_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_word  (random_word),
        .source       (source),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver side: a requested hold-off overrides the random stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall = 1'b0;
        else if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
            out_stall = 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall = 1'b1;
        end
        else
            out_stall = ($urandom_range(99) < stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // zero, all ones or random
    function automatic logic [63:0] pick64();
        case ($urandom_range(3))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    task write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // Hold until every draw is answered, then let a pending init finish.
    task wait_drained();
        in_valid = 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task send_word(input logic k, input logic [63:0] t, input logic [63:0] h,
                   input logic o);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind     = k;
        tsc_now  = t;
        hw_word  = h;
        hw_ok    = o;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_random_word();
        logic k;
        k = ($urandom_range(99) < 4) ? KIND_INIT : KIND_DRAW;
        send_word(k, rand64(), rand64(), 1'($urandom_range(1)));
    endtask

    task load_random_config();
        write_reg(CFG_TSC_FIRST, pick64());
        write_reg(CFG_TSC_SECOND, pick64());
        write_reg(CFG_CLOCK_BYTES, pick64());
        write_reg(CFG_HAS_HW, rand64());
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = CFG_TSC_FIRST;
        cfg_data        = 64'h0;
        in_valid        = 1'b0;
        kind            = KIND_INIT;
        tsc_now         = 64'h0;
        hw_word         = 64'h0;
        hw_ok           = 1'b0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_trigger    = 0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // draws before any init return the masked timestamp
        send_word(KIND_DRAW, 64'h0, 64'h0, 1'b0);
        send_word(KIND_DRAW, '1, '1, 1'b1);
        wait_drained();
        write_reg(CFG_HAS_HW, 64'h1);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b1);

        // seeds from all-zero registers, then the hardware paths
        wait_drained();
        write_reg(CFG_TSC_FIRST, 64'h0);
        write_reg(CFG_TSC_SECOND, 64'h0);
        write_reg(CFG_CLOCK_BYTES, 64'h0);
        send_word(KIND_INIT, rand64(), rand64(), 1'b0);
        send_word(KIND_DRAW, rand64(), 64'h0, 1'b1);
        send_word(KIND_DRAW, rand64(), '1, 1'b1);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b0);

        // no hardware source: hw fields are don't-care; back-to-back reinit
        wait_drained();
        write_reg(CFG_HAS_HW, 64'h0);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b1);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b0);
        send_word(KIND_INIT, rand64(), rand64(), 1'b1);
        send_word(KIND_INIT, rand64(), rand64(), 1'b0);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b0);

        // all-ones registers
        wait_drained();
        write_reg(CFG_TSC_FIRST, '1);
        write_reg(CFG_TSC_SECOND, '1);
        write_reg(CFG_CLOCK_BYTES, 64'hFF_FFFF);
        write_reg(CFG_HAS_HW, 64'h1);
        send_word(KIND_INIT, 64'h0, 64'h0, 1'b0);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b0);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b1);

        // seed zero finalizes to zero and gets the substitute constant
        wait_drained();
        write_reg(CFG_TSC_FIRST, 64'h0 - GOLDEN_INC);
        write_reg(CFG_TSC_SECOND, 64'h0);
        write_reg(CFG_CLOCK_BYTES, 64'h0);
        send_word(KIND_INIT, '1, '1, 1'b1);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b1);
        send_word(KIND_DRAW, rand64(), rand64(), 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                1:
                begin
                    sender_idle_pct = 58;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 58;
                end
                3:
                begin
                    sender_idle_pct = 6;
                    stall_pct       = 6;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
            endcase
            load_random_config();
            if (p == PRESSURE_PHASE)
                hold_trigger++;
            send_word(KIND_INIT, rand64(), rand64(), 1'($urandom_range(1)));
            repeat (ITEMS_PER_PHASE) send_random_word();
        end

        wait_drained();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
